/* hdl/ilst_pkg.sv */
// Shared types and codes for the indexed list store.
package ilst_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int CNT_OUT_W = 5;

  typedef logic [1:0] action_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_READ   = 2'd2;
  localparam action_t ACT_CLEAR  = 2'd3;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cmd_t;

endpackage

/* hdl/ilst_cell.sv */
// One list cell: holds a value, shifts from a neighbour and joins the read chain.
module ilst_cell #(
  parameter int IDX = 0,
  parameter int W   = 5
) (
  input  logic          clk,
  input  ilst_pkg::cmd_t cmd,
  input  logic [W-1:0]  pos,
  input  logic [W-1:0]  cnt,
  input  ilst_pkg::value_t ins_value,
  input  ilst_pkg::value_t left_value,
  input  ilst_pkg::value_t right_value,
  input  ilst_pkg::value_t rd_in,
  output ilst_pkg::value_t val,
  output ilst_pkg::value_t rd_out
);
  import ilst_pkg::*;

  localparam logic [W-1:0] MY_IDX  = W'(IDX);
  localparam logic [W:0]   MY_NEXT = (W+1)'(IDX + 1);

  value_t val_r;
  value_t val_nxt;
  logic   at_pos;

  assign at_pos = (pos == MY_IDX);

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (at_pos) begin
        val_nxt = ins_value;
      end else if (MY_IDX > pos && MY_IDX <= cnt) begin
        val_nxt = left_value;
      end
    end else if (cmd.rem) begin
      if (MY_IDX >= pos && MY_NEXT < {1'b0, cnt}) begin
        val_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  assign rd_out = at_pos ? (rd_in | val_r) : rd_in;

endmodule

/* hdl/indexed_list_store_core.sv */
// Indexed list store: ordered list held in a chain of shifting cells.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_action,          | request in
//           | in_position, in_value                   |
//   out     | out_valid, out_stall, out_ok,           | result out
//           | out_read_value, out_count               |
//
// One item per cycle unless the result stalls: every cell decides its own shift
// from the broadcast request, and the read is an OR chain through the cells into
// the result register. A result appears in the cycle after its item is taken.
// Synchronous active-low reset empties the list; cell contents are not cleared.
// A stalled result holds the input stalled until it is taken.
module indexed_list_store_core #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ilst_pkg::action_t             in_action,
  input  logic [ilst_pkg::POS_W-1:0]    in_position,
  input  ilst_pkg::value_t              in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output ilst_pkg::value_t              out_read_value,
  output logic [ilst_pkg::CNT_OUT_W-1:0] out_count
);
  import ilst_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = (CW > POS_W) ? CW : POS_W;
  localparam logic [W-1:0] DEPTH_W = W'(DEPTH);

  logic [W-1:0] count_r;
  logic [W-1:0] count_nxt;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         out_ok_r;
  value_t       out_read_value_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  logic         accept;
  logic [W-1:0] pos;
  logic         ins_ok;
  logic         hit_ok;
  logic         ok;
  cmd_t         cmd;
  value_t       read_value;

  value_t vals [DEPTH];
  value_t rd_chain [DEPTH+1];

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign pos      = W'(in_position);

  assign ins_ok = (count_r < DEPTH_W) && (pos <= count_r);
  assign hit_ok = (pos < count_r);

  always_comb begin
    ok        = 1'b0;
    cmd       = '0;
    count_nxt = count_r;
    case (in_action)
      ACT_INSERT: begin
        ok      = ins_ok;
        cmd.ins = accept & ins_ok;
        if (accept && ins_ok) begin
          count_nxt = count_r + W'(1);
        end
      end
      ACT_REMOVE: begin
        ok      = hit_ok;
        cmd.rem = accept & hit_ok;
        if (accept && hit_ok) begin
          count_nxt = count_r - W'(1);
        end
      end
      ACT_READ: begin
        ok = hit_ok;
      end
      default: begin
        ok = 1'b1;
        if (accept) begin
          count_nxt = '0;
        end
      end
    endcase
  end

  assign rd_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t left_v;
    value_t right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end
    ilst_cell #(
      .IDX (i),
      .W   (W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos),
      .cnt         (count_r),
      .ins_value   (in_value),
      .left_value  (left_v),
      .right_value (right_v),
      .rd_in       (rd_chain[i]),
      .val         (vals[i]),
      .rd_out      (rd_chain[i+1])
    );
  end

  assign read_value = (in_action == ACT_READ && hit_ok) ? rd_chain[DEPTH] : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r         <= ok;
      out_read_value_r <= read_value;
      out_count_r      <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_W)
    else $error("list count beyond depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item gave no result");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count moved without an item");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_action == ACT_CLEAR |=> count_r == '0 && out_ok_r)
    else $error("clear left entries");

  a_read_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_read_value_r != '0 |-> out_ok_r)
    else $error("value returned on a rejected item");

endmodule
